// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion helpers used by the core rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/b85hd_pkg.sv -----
// ---------------------------------------------------------------------------
// b85hd_pkg
// types, constants and the symbol lookup for the base85 hunk decoder
// ---------------------------------------------------------------------------
package b85hd_pkg;

    localparam int HUNK_CHARS = 5;
    localparam logic [6:0] PAD_DIGIT = 7'd84;
    localparam logic [2:0] MAX_COUNT = 3'd5;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // radix 85 weights, first character most significant
    typedef logic [32:0] weight_t;
    localparam weight_t WEIGHTS [HUNK_CHARS] = '{
        33'd52200625, 33'd614125, 33'd7225, 33'd85, 33'd1
    };

    typedef struct packed {
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic [7:0] byte_c;
        logic [7:0] byte_d;
        logic [2:0] byte_count;
        status_t    status;
    } result_t;

    // {hit, digit}; hit low when the byte is outside the alphabet
    function automatic logic [7:0] sym_digit(input logic [7:0] c);
        logic [7:0] r;
        r = 8'd0;
        case (c) inside
            [8'h30:8'h39]: r = {1'b1, 7'(c - 8'h30)};
            [8'h41:8'h5a]: r = {1'b1, 7'(c - 8'h41 + 8'd10)};
            [8'h61:8'h7a]: r = {1'b1, 7'(c - 8'h61 + 8'd36)};
            8'h21: r = {1'b1, 7'd62};
            8'h23: r = {1'b1, 7'd63};
            8'h24: r = {1'b1, 7'd64};
            8'h25: r = {1'b1, 7'd65};
            8'h26: r = {1'b1, 7'd66};
            8'h28: r = {1'b1, 7'd67};
            8'h29: r = {1'b1, 7'd68};
            8'h2a: r = {1'b1, 7'd69};
            8'h2b: r = {1'b1, 7'd70};
            8'h2d: r = {1'b1, 7'd71};
            8'h3b: r = {1'b1, 7'd72};
            8'h3c: r = {1'b1, 7'd73};
            8'h3d: r = {1'b1, 7'd74};
            8'h3e: r = {1'b1, 7'd75};
            8'h3f: r = {1'b1, 7'd76};
            8'h40: r = {1'b1, 7'd77};
            8'h5e: r = {1'b1, 7'd78};
            8'h5f: r = {1'b1, 7'd79};
            8'h60: r = {1'b1, 7'd80};
            8'h7b: r = {1'b1, 7'd81};
            8'h7c: r = {1'b1, 7'd82};
            8'h7d: r = {1'b1, 7'd83};
            8'h7e: r = {1'b1, 7'd84};
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/b85hd_calc.sv -----
// ---------------------------------------------------------------------------
// b85hd_calc
// combinational decode of one registered hunk into bytes, count and status
// ---------------------------------------------------------------------------
module b85hd_calc (
    input  logic [7:0]        char_a,
    input  logic [7:0]        char_b,
    input  logic [7:0]        char_c,
    input  logic [7:0]        char_d,
    input  logic [7:0]        char_e,
    input  logic [2:0]        char_count,
    output b85hd_pkg::result_t result
);
    import b85hd_pkg::*;

    logic [7:0]  chars [HUNK_CHARS];
    logic [7:0]  lookup [HUNK_CHARS];
    logic [6:0]  digit [HUNK_CHARS];
    logic [32:0] term [HUNK_CHARS];
    logic [HUNK_CHARS-1:0] in_use;
    logic [HUNK_CHARS-1:0] bad;
    logic [2:0]  count_sat;
    logic [32:0] acc;

    assign chars[0] = char_a;
    assign chars[1] = char_b;
    assign chars[2] = char_c;
    assign chars[3] = char_d;
    assign chars[4] = char_e;

    assign count_sat = (char_count > MAX_COUNT) ? MAX_COUNT : char_count;

    always_comb
    begin
        for (int i = 0; i < HUNK_CHARS; i++)
        begin
            lookup[i] = sym_digit(chars[i]);
            in_use[i] = (3'(i) < count_sat);
            bad[i]    = in_use[i] & ~lookup[i][7];
            digit[i]  = in_use[i] ? lookup[i][6:0] : PAD_DIGIT;
            term[i]   = 33'(digit[i]) * WEIGHTS[i];
        end
        acc = term[0] + term[1] + term[2] + term[3] + term[4];
    end

    always_comb
    begin
        result = '0;
        if (|bad)
        begin
            result.status = ST_BAD_CHAR;
        end
        else if (acc[32])
        begin
            result.status = ST_OVERFLOW;
        end
        else
        begin
            result.byte_a     = acc[31:24];
            result.byte_b     = acc[23:16];
            result.byte_c     = acc[15:8];
            result.byte_d     = acc[7:0];
            result.byte_count = count_sat - 3'd1;
            result.status     = ST_OK;
        end
    end

endmodule

// ----- rtl/core/base85_hunk_decoder_core.sv -----
// ---------------------------------------------------------------------------
// base85_hunk_decoder_core
// decodes one five-character base85 hunk per beat into four bytes
// ---------------------------------------------------------------------------
// usage:
//   hunk channel (hunk_valid/hunk_ready) carries char_a..char_e and
//   char_count; word channel (word_valid/word_ready) returns byte_a..byte_d,
//   byte_count and status, one word beat for every hunk beat, in order.
//   an accepted hunk sits in the input register until the decode logic
//   loads its word into the free result register, which drives word_valid.
//   throughput is one hunk per cycle while word_ready stays high, set by
//   the two-stage register pipe.
//   if the receiver holds word_ready low the result register holds its
//   word, the input register fills, and hunk_ready drops after that; both
//   stages advance together again once word_ready returns.
//   reset empties both stages; hunk_ready is high right after reset.
//   on a bad character or an overflow the bytes and byte_count are zero.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module base85_hunk_decoder_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       hunk_valid,
    output logic       hunk_ready,
    input  logic [7:0] char_a,
    input  logic [7:0] char_b,
    input  logic [7:0] char_c,
    input  logic [7:0] char_d,
    input  logic [7:0] char_e,
    input  logic [2:0] char_count,
    output logic       word_valid,
    input  logic       word_ready,
    output logic [7:0] byte_a,
    output logic [7:0] byte_b,
    output logic [7:0] byte_c,
    output logic [7:0] byte_d,
    output logic [2:0] byte_count,
    output logic [1:0] status
);
    import b85hd_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] ca_reg, cb_reg, cc_reg, cd_reg, ce_reg;
    logic [2:0] cnt_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    res_reg;
    result_t    res_next;
    logic       out_free;
    logic       in_move;
    logic       hunk_take;

    b85hd_calc u_calc (
        .char_a     (ca_reg),
        .char_b     (cb_reg),
        .char_c     (cc_reg),
        .char_d     (cd_reg),
        .char_e     (ce_reg),
        .char_count (cnt_reg),
        .result     (res_next)
    );

    assign out_free   = ~out_valid_reg | word_ready;
    assign in_move    = in_valid_reg & out_free;
    assign hunk_ready = ~in_valid_reg | out_free;
    assign hunk_take  = hunk_valid & hunk_ready;

    assign in_valid_next  = hunk_take | (in_valid_reg & ~out_free);
    assign out_valid_next = in_move | (out_valid_reg & ~word_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hunk_take)
        begin
            ca_reg  <= char_a;
            cb_reg  <= char_b;
            cc_reg  <= char_c;
            cd_reg  <= char_d;
            ce_reg  <= char_e;
            cnt_reg <= char_count;
        end
        if (in_move)
        begin
            res_reg <= res_next;
        end
    end

    assign word_valid = out_valid_reg;
    assign byte_a     = res_reg.byte_a;
    assign byte_b     = res_reg.byte_b;
    assign byte_c     = res_reg.byte_c;
    assign byte_d     = res_reg.byte_d;
    assign byte_count = res_reg.byte_count;
    assign status     = res_reg.status;

    // an error beat never carries data
    `ASSERT_IMPL(a_err_zero, clk, rst_n,
        out_valid_reg && res_reg.status != ST_OK,
        res_reg.byte_count == 3'd0 && res_reg.byte_a == 8'd0 && res_reg.byte_b == 8'd0
        && res_reg.byte_c == 8'd0 && res_reg.byte_d == 8'd0)

    // a good word never claims more than four bytes
    `ASSERT_IMPL(a_ok_count, clk, rst_n,
        out_valid_reg && res_reg.status == ST_OK,
        res_reg.byte_count <= 3'd4)

    // a hunk held behind a stalled result is not dropped
    `ASSERT_NEXT(a_in_hold, clk, rst_n,
        in_valid_reg && !out_free,
        in_valid_reg && out_valid_reg)

    // a decoded hunk always shows up on the word side next cycle
    `ASSERT_NEXT(a_move_out, clk, rst_n, in_move, out_valid_reg)

endmodule

// ----- tb/tb_base85_hunk_decoder_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_base85_hunk_decoder_core
// self-checking bench for the base85 hunk decoder: a short table of directed
// hunks, then random hunks, every word beat compared field by field against
// the table's word or a decoder kept inside the bench, with random stalls
// on both channels
module tb_base85_hunk_decoder_core;
    import b85hd_pkg::*;

    localparam int RANDOM_HUNKS = 700;
    localparam int QUIET_TAIL   = 100;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 120;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    localparam logic [7:0] PUNCT_SYMS [23] = '{
        8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2d, 8'h3b, 8'h3c,
        8'h3d, 8'h3e, 8'h3f, 8'h40, 8'h5e, 8'h5f, 8'h60, 8'h7b, 8'h7c, 8'h7d, 8'h7e
    };

    localparam result_t ZERO_WORD = '{8'h00, 8'h00, 8'h00, 8'h00, 3'd4, ST_OK};
    localparam result_t FULL_WORD = '{8'hff, 8'hff, 8'hff, 8'hff, 3'd4, ST_OK};
    localparam result_t BAD_WORD  = '{8'h00, 8'h00, 8'h00, 8'h00, 3'd0, ST_BAD_CHAR};
    localparam result_t OVF_WORD  = '{8'h00, 8'h00, 8'h00, 8'h00, 3'd0, ST_OVERFLOW};
    localparam result_t UNTYPED   = '0;

    typedef struct {
        logic [39:0] chars;
        logic [2:0]  count;
        bit          typed;
        result_t     word;
    } hunk_row_t;

    logic       clk;
    logic       rst_n;
    logic       hunk_valid;
    logic       hunk_ready;
    logic [7:0] char_a;
    logic [7:0] char_b;
    logic [7:0] char_c;
    logic [7:0] char_d;
    logic [7:0] char_e;
    logic [2:0] char_count;
    logic       word_valid;
    logic       word_ready;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;
    logic [7:0] byte_d;
    logic [2:0] byte_count;
    logic [1:0] status;

    int         symbol_value [256];
    logic [7:0] digit_symbol [85];
    hunk_row_t  directed_rows [$];
    result_t    expected_words [$];
    result_t    pending_word;
    bit         hold_req = 1'b0;
    bit         quiet_tail = 1'b0;

    int cycle_count    = 0;
    int mismatch_count = 0;
    int words_checked  = 0;
    int hunks_sent     = 0;
    int ok_words       = 0;
    int bad_words      = 0;
    int ovf_words      = 0;

    base85_hunk_decoder_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .hunk_valid (hunk_valid),
        .hunk_ready (hunk_ready),
        .char_a     (char_a),
        .char_b     (char_b),
        .char_c     (char_c),
        .char_d     (char_d),
        .char_e     (char_e),
        .char_count (char_count),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .byte_a     (byte_a),
        .byte_b     (byte_b),
        .byte_c     (byte_c),
        .byte_d     (byte_d),
        .byte_count (byte_count),
        .status     (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d words still expected", cycle_count,
                 expected_words.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void build_symbol_tables();
        int k;
        for (k = 0; k < 256; k++)
            symbol_value[k] = -1;
        for (k = 0; k < 10; k++)
            digit_symbol[k] = 8'(48 + k);
        for (k = 0; k < 26; k++)
        begin
            digit_symbol[10 + k] = 8'(65 + k);
            digit_symbol[36 + k] = 8'(97 + k);
        end
        for (k = 0; k < 23; k++)
            digit_symbol[62 + k] = PUNCT_SYMS[k];
        for (k = 0; k < 85; k++)
            symbol_value[digit_symbol[k]] = k;
    endfunction

    // radix 85 decode of one hunk; unused positions pad with the top digit
    function automatic result_t decode_hunk(input logic [39:0] chars, input logic [2:0] count);
        result_t    word;
        logic [63:0] acc;
        int         used;
        int         digit;
        int         i;
        status_t    st;
        used = (count > 3'd5) ? 5 : int'(count);
        acc = '0;
        st = ST_OK;
        for (i = 0; i < 5; i++)
        begin
            if (st == ST_OK)
            begin
                digit = 84;
                if (i < used)
                    digit = symbol_value[chars[39 - 8*i -: 8]];
                if (digit < 0)
                    st = ST_BAD_CHAR;
                else
                    acc = acc * 64'd85 + 64'(digit);
            end
        end
        if (st == ST_OK && acc > 64'h0000_0000_ffff_ffff)
            st = ST_OVERFLOW;
        word = '0;
        word.status = st;
        if (st == ST_OK)
        begin
            word.byte_a = acc[31:24];
            word.byte_b = acc[23:16];
            word.byte_c = acc[15:8];
            word.byte_d = acc[7:0];
            word.byte_count = 3'(used - 1);
        end
        return word;
    endfunction

    task automatic add_row(input logic [39:0] chars, input logic [2:0] count, input bit typed,
                           input result_t word);
        hunk_row_t row;
        row.chars = chars;
        row.count = count;
        row.typed = typed;
        row.word = word;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic make_random_hunk(output logic [39:0] chars, output logic [2:0] count);
        int         kind;
        int         i;
        int         pos;
        logic [7:0] junk;
        for (i = 0; i < 5; i++)
            chars[39 - 8*i -: 8] = 8'($urandom_range(0, 255));
        kind = $urandom_range(0, 99);
        if (kind < 60)
        begin
            // well formed, junk left in the unused positions
            count = 3'($urandom_range(1, 5));
            if ($urandom_range(0, 9) == 0)
                count = 3'($urandom_range(5, 7));
            for (i = 0; i < 5; i++)
                if (i < int'(count))
                    chars[39 - 8*i -: 8] = digit_symbol[$urandom_range(0, 84)];
            // high leading digit lands near the 32-bit edge
            if ($urandom_range(0, 3) == 0)
                chars[39:32] = digit_symbol[$urandom_range(80, 84)];
        end
        else if (kind < 80)
        begin
            count = 3'($urandom_range(1, 5));
            for (i = 0; i < 5; i++)
                if (i < int'(count))
                    chars[39 - 8*i -: 8] = digit_symbol[$urandom_range(0, 84)];
            do
                junk = 8'($urandom_range(0, 255));
            while (symbol_value[junk] >= 0);
            pos = $urandom_range(0, int'(count) - 1);
            chars[39 - 8*pos -: 8] = junk;
        end
        else
        begin
            count = 3'($urandom_range(0, 7));
        end
    endtask

    // hunk beats queue up, word beats pop and compare, in one process
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (hunk_valid && hunk_ready)
            begin
                expected_words.insert(expected_words.size(), pending_word);
                hunks_sent++;
            end
            if (word_valid && word_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("word beat with nothing expected: ",
                                 "%02h %02h %02h %02h cnt %0d st %0d",
                                 byte_a, byte_b, byte_c, byte_d, byte_count, status);
                end
                else
                begin
                    want = expected_words.pop_front();
                    words_checked++;
                    case (want.status)
                        ST_OK:       ok_words++;
                        ST_BAD_CHAR: bad_words++;
                        default:     ovf_words++;
                    endcase
                    if (byte_a !== want.byte_a || byte_b !== want.byte_b ||
                        byte_c !== want.byte_c || byte_d !== want.byte_d ||
                        byte_count !== want.byte_count || status !== want.status)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("word %0d: expected %02h %02h %02h %02h cnt %0d st %0d,",
                                     words_checked, want.byte_a, want.byte_b, want.byte_c,
                                     want.byte_d, want.byte_count, want.status,
                                     " got %02h %02h %02h %02h cnt %0d st %0d", byte_a,
                                     byte_b, byte_c, byte_d, byte_count, status);
                    end
                end
            end
        end
    end

    // word side: random stall bursts, one long hold, none in the tail
    initial
    begin
        bit hold_done;
        word_ready = 1'b0;
        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                word_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                word_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            word_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    // hunk side
    initial
    begin
        hunk_row_t   row;
        logic [39:0] chars;
        logic [2:0]  count;
        result_t     word;
        int          n;
        int          total;
        int          gap;
        int          pause_at;
        int          hold_at;

        rst_n = 1'b0;
        hunk_valid = 1'b0;
        char_a = 8'h00;
        char_b = 8'h00;
        char_c = 8'h00;
        char_d = 8'h00;
        char_e = 8'h00;
        char_count = 3'd0;
        pending_word = '0;
        build_symbol_tables();

        add_row("00000", 3'd5, 1'b1, ZERO_WORD);
        add_row("|NsC0", 3'd5, 1'b1, FULL_WORD);
        add_row("|NsC1", 3'd5, 1'b1, OVF_WORD);
        add_row("~~~~~", 3'd5, 1'b1, OVF_WORD);
        add_row({8'h00, "0000"}, 3'd5, 1'b1, BAD_WORD);
        add_row({"0000", 8'hff}, 3'd5, 1'b1, BAD_WORD);
        // bad byte past the count is never looked at
        add_row({"0000", 8'hff}, 3'd4, 1'b0, UNTYPED);
        // bad character wins over a value that would overflow
        add_row({"~~~~", 8'h22}, 3'd5, 1'b1, BAD_WORD);
        // zero count is all padding, which overflows
        add_row("00000", 3'd0, 1'b1, OVF_WORD);
        add_row("0~~~~", 3'd1, 1'b0, UNTYPED);
        add_row({"z", 8'h00, 8'hff, 8'h80, 8'h7f}, 3'd1, 1'b0, UNTYPED);
        add_row("12345", 3'd6, 1'b0, UNTYPED);
        add_row("abcde", 3'd7, 1'b0, UNTYPED);
        add_row("!#$%&", 3'd5, 1'b0, UNTYPED);
        add_row("()*+-", 3'd5, 1'b0, UNTYPED);
        add_row(";<=>?", 3'd5, 1'b0, UNTYPED);
        add_row({"@^_", 8'h60, "{"}, 3'd5, 1'b0, UNTYPED);
        add_row("|}~zZ", 3'd5, 1'b0, UNTYPED);
        add_row("9Zz~0", 3'd3, 1'b0, UNTYPED);
        add_row("AYay0", 3'd2, 1'b0, UNTYPED);
        add_row("/0000", 3'd5, 1'b1, BAD_WORD);
        add_row({"0", ":", "000"}, 3'd5, 1'b1, BAD_WORD);
        add_row({"00", "[", "00"}, 3'd5, 1'b1, BAD_WORD);
        add_row({"000", 8'h7f, "0"}, 3'd5, 1'b1, BAD_WORD);
        add_row({"0", 8'h20, "000"}, 3'd2, 1'b1, BAD_WORD);

        total = directed_rows.size() + RANDOM_HUNKS;
        hold_at = directed_rows.size() + 150;
        pause_at = directed_rows.size() + 320;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (n = 0; n < total; n++)
        begin
            if (n < directed_rows.size())
            begin
                row = directed_rows[n];
                chars = row.chars;
                count = row.count;
                word = row.typed ? row.word : decode_hunk(chars, count);
            end
            else
            begin
                make_random_hunk(chars, count);
                word = decode_hunk(chars, count);
            end

            gap = 0;
            if (n < total - QUIET_TAIL && $urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 19);
            if (n == pause_at || gap > 0)
            begin
                hunk_valid <= 1'b0;
                repeat (gap) @(posedge clk);
                if (n == pause_at)
                begin
                    // let the pipe run dry before going on
                    @(posedge clk);
                    while (expected_words.size() != 0)
                        @(posedge clk);
                    @(posedge clk);
                end
            end
            if (n == hold_at)
                hold_req <= 1'b1;
            if (n == total - QUIET_TAIL)
                quiet_tail <= 1'b1;

            hunk_valid <= 1'b1;
            char_a <= chars[39:32];
            char_b <= chars[31:24];
            char_c <= chars[23:16];
            char_d <= chars[15:8];
            char_e <= chars[7:0];
            char_count <= count;
            pending_word <= word;
            @(posedge clk);
            while (!hunk_ready)
                @(posedge clk);
        end
        hunk_valid <= 1'b0;

        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d hunks in, %0d word beats checked: %0d ok, %0d bad character, %0d overflow",
                 hunks_sent, words_checked, ok_words, bad_words, ovf_words);
        $display("counts 0 to 7, every symbol, junk in unused slots, stalls both sides, %0d bad",
                 mismatch_count);
        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
